// ===== rtl/a64_subset_instruction_decoder_defines.svh =====
// ----------------------------------------------------------------------------
// A64 subset decoder assertion macros
// Shared concurrent assertion forms, clocked on clk with synchronous reset.
// ----------------------------------------------------------------------------
`ifndef A64_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH
`define A64_SUBSET_INSTRUCTION_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define A64D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define A64D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/a64dec_pkg.sv =====
// ----------------------------------------------------------------------------
// A64 subset decoder package
// Instruction class codes, encoding masks and the decoded result type.
// ----------------------------------------------------------------------------
package a64dec_pkg;

  // Instruction class codes, in decoder priority order.
  localparam logic [4:0] CLS_UNKNOWN   = 5'd0;
  localparam logic [4:0] CLS_PACIASP   = 5'd1;
  localparam logic [4:0] CLS_ADRP      = 5'd2;
  localparam logic [4:0] CLS_ADD_X     = 5'd3;
  localparam logic [4:0] CLS_LDR_X     = 5'd4;
  localparam logic [4:0] CLS_STR_X     = 5'd5;
  localparam logic [4:0] CLS_LDR_W     = 5'd6;
  localparam logic [4:0] CLS_STR_W     = 5'd7;
  localparam logic [4:0] CLS_LDRB      = 5'd8;
  localparam logic [4:0] CLS_STRB      = 5'd9;
  localparam logic [4:0] CLS_STRB_POST = 5'd10;
  localparam logic [4:0] CLS_STRB_PRE  = 5'd11;
  localparam logic [4:0] CLS_MOV_X     = 5'd12;
  localparam logic [4:0] CLS_MOV_W     = 5'd13;
  localparam logic [4:0] CLS_MOVZ_W    = 5'd14;
  localparam logic [4:0] CLS_CMP_W     = 5'd15;
  localparam logic [4:0] CLS_UBFM_W    = 5'd16;
  localparam logic [4:0] CLS_CBZ_W     = 5'd17;
  localparam logic [4:0] CLS_CBZ_X     = 5'd18;
  localparam logic [4:0] CLS_CBNZ_W    = 5'd19;
  localparam logic [4:0] CLS_CBNZ_X    = 5'd20;
  localparam logic [4:0] CLS_BCOND     = 5'd21;

  // Exact encoding of PACIASP.
  localparam logic [31:0] ENC_PACIASP   = 32'hD503233F;

  // Mask and match pairs.
  localparam logic [31:0] MSK_ADRP      = 32'h9F000000;
  localparam logic [31:0] MAT_ADRP      = 32'h90000000;
  localparam logic [31:0] MSK_ADD_X     = 32'hFF800000;
  localparam logic [31:0] MAT_ADD_X     = 32'h91000000;
  localparam logic [31:0] MSK_LDST      = 32'hFFC00000;
  localparam logic [31:0] MAT_LDR_X     = 32'hF9400000;
  localparam logic [31:0] MAT_STR_X     = 32'hF9000000;
  localparam logic [31:0] MAT_LDR_W     = 32'hB9400000;
  localparam logic [31:0] MAT_STR_W     = 32'hB9000000;
  localparam logic [31:0] MAT_LDRB      = 32'h39400000;
  localparam logic [31:0] MAT_STRB      = 32'h39000000;
  localparam logic [31:0] MSK_STRB_IDX  = 32'hFFE00C00;
  localparam logic [31:0] MAT_STRB_POST = 32'h38000400;
  localparam logic [31:0] MAT_STRB_PRE  = 32'h38000C00;
  localparam logic [31:0] MSK_MOV       = 32'hFFE0FFE0;
  localparam logic [31:0] MAT_MOV_X     = 32'hAA0003E0;
  localparam logic [31:0] MAT_MOV_W     = 32'h2A0003E0;
  localparam logic [31:0] MSK_MOVZ      = 32'hFF800000;
  localparam logic [31:0] MAT_MOVZ_W    = 32'h52800000;
  localparam logic [31:0] MSK_CMP       = 32'hFF80001F;
  localparam logic [31:0] MAT_CMP_W     = 32'h7100001F;
  localparam logic [31:0] MAT_UBFM_W    = 32'h53000000;
  localparam logic [31:0] MSK_CB        = 32'h7E000000;
  localparam logic [31:0] MAT_CB        = 32'h34000000;
  localparam logic [31:0] MSK_BCOND     = 32'hFF000010;
  localparam logic [31:0] MAT_BCOND     = 32'h54000000;

  // Register number used for the zero register in MOV and CMP aliases.
  localparam logic [4:0] REG_ZR = 5'd31;

  // One decoded result item.
  typedef struct packed {
    logic [4:0]  inst_class;
    logic [4:0]  reg_t;
    logic [4:0]  reg_n;
    logic [4:0]  reg_m;
    logic [31:0] uimm;
    logic [31:0] simm;
    logic [5:0]  shift_amount;
    logic [3:0]  cond_code;
    logic        target_valid;
    logic [63:0] branch_target;
  } dec_result_t;

endpackage

// ===== rtl/a64_subset_instruction_decoder.sv =====
// ----------------------------------------------------------------------------
// A64 subset instruction decoder
// Classifies one A64 instruction word and extracts its operand fields.
// ----------------------------------------------------------------------------
// The decoder takes one instruction word and its byte offset per transfer and
// returns one decoded result per transfer, sustaining one word per clock while
// the result side accepts; the word is captured in an input register, decoded
// by priority mask/match logic, and the fields plus the 64-bit branch target
// adder feed the result register. When the result side holds off, the result
// register keeps its transfer and the input register fills behind it; a new
// word is then accepted only while the input register is still empty.
`include "a64_subset_instruction_decoder_defines.svh"

module a64_subset_instruction_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_instr_word,
  input  logic signed [63:0] in_inst_offset,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [4:0]         out_inst_class,
  output logic [4:0]         out_reg_t,
  output logic [4:0]         out_reg_n,
  output logic [4:0]         out_reg_m,
  output logic [31:0]        out_uimm,
  output logic signed [31:0] out_simm,
  output logic [5:0]         out_shift_amount,
  output logic [3:0]         out_cond_code,
  output logic               out_target_valid,
  output logic signed [63:0] out_branch_target
);

  // Input stage registers.
  logic        s0_valid_r;
  logic [31:0] s0_word_r;
  logic [63:0] s0_offset_r;

  // Result stage registers.
  logic                    out_valid_r;
  a64dec_pkg::dec_result_t res_r;
  a64dec_pkg::dec_result_t res_nxt;

  logic s1_ready;
  logic in_xfer;
  logic s1_load;

  // Stage handshakes: each stage takes data when it is empty or draining.
  assign s1_ready = !out_valid_r || out_ready;
  assign in_ready = !s0_valid_r || s1_ready;
  assign in_xfer  = in_valid && in_ready;
  assign s1_load  = s0_valid_r && s1_ready;

  // Input stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_ready) begin
      s0_valid_r <= in_valid;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s0_word_r   <= in_instr_word;
      s0_offset_r <= in_inst_offset;
    end
  end

  // Priority decode of the captured word; the first matching pattern wins.
  always_comb begin
    logic [31:0] w;
    logic [31:0] br_off;
    logic [31:0] imm9;
    w      = s0_word_r;
    br_off = {{11{w[23]}}, w[23:5], 2'b00};
    imm9   = {{23{w[20]}}, w[20:12]};

    res_nxt = '0;
    if (w == a64dec_pkg::ENC_PACIASP) begin
      res_nxt.inst_class = a64dec_pkg::CLS_PACIASP;
    end else if ((w & a64dec_pkg::MSK_ADRP) == a64dec_pkg::MAT_ADRP) begin
      res_nxt.inst_class = a64dec_pkg::CLS_ADRP;
      res_nxt.reg_t      = w[4:0];
      // Page offset keeps the low 20 bits of imm21 above a 4 KiB page.
      res_nxt.simm       = {w[22:5], w[30:29], 12'h000};
    end else if ((w & a64dec_pkg::MSK_ADD_X) == a64dec_pkg::MAT_ADD_X) begin
      res_nxt.inst_class = a64dec_pkg::CLS_ADD_X;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      if (w[22]) begin
        res_nxt.shift_amount = 6'd12;
        res_nxt.uimm         = {8'h00, w[21:10], 12'h000};
      end else begin
        res_nxt.uimm = {20'h00000, w[21:10]};
      end
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_LDR_X) begin
      res_nxt.inst_class = a64dec_pkg::CLS_LDR_X;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {17'h00000, w[21:10], 3'b000};
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_STR_X) begin
      res_nxt.inst_class = a64dec_pkg::CLS_STR_X;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {17'h00000, w[21:10], 3'b000};
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_LDR_W) begin
      res_nxt.inst_class = a64dec_pkg::CLS_LDR_W;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {18'h00000, w[21:10], 2'b00};
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_STR_W) begin
      res_nxt.inst_class = a64dec_pkg::CLS_STR_W;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {18'h00000, w[21:10], 2'b00};
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_LDRB) begin
      res_nxt.inst_class = a64dec_pkg::CLS_LDRB;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {20'h00000, w[21:10]};
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_STRB) begin
      res_nxt.inst_class = a64dec_pkg::CLS_STRB;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {20'h00000, w[21:10]};
    end else if ((w & a64dec_pkg::MSK_STRB_IDX) == a64dec_pkg::MAT_STRB_POST) begin
      res_nxt.inst_class = a64dec_pkg::CLS_STRB_POST;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.simm       = imm9;
      res_nxt.uimm       = imm9;
    end else if ((w & a64dec_pkg::MSK_STRB_IDX) == a64dec_pkg::MAT_STRB_PRE) begin
      res_nxt.inst_class = a64dec_pkg::CLS_STRB_PRE;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.simm       = imm9;
      res_nxt.uimm       = imm9;
    end else if ((w & a64dec_pkg::MSK_MOV) == a64dec_pkg::MAT_MOV_X) begin
      res_nxt.inst_class = a64dec_pkg::CLS_MOV_X;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_m      = w[20:16];
      res_nxt.reg_n      = a64dec_pkg::REG_ZR;
    end else if ((w & a64dec_pkg::MSK_MOV) == a64dec_pkg::MAT_MOV_W) begin
      res_nxt.inst_class = a64dec_pkg::CLS_MOV_W;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_m      = w[20:16];
      res_nxt.reg_n      = a64dec_pkg::REG_ZR;
    end else if ((w & a64dec_pkg::MSK_MOVZ) == a64dec_pkg::MAT_MOVZ_W) begin
      res_nxt.inst_class   = a64dec_pkg::CLS_MOVZ_W;
      res_nxt.reg_t        = w[4:0];
      res_nxt.uimm         = {16'h0000, w[20:5]};
      res_nxt.shift_amount = {w[22:21], 4'h0};
    end else if ((w & a64dec_pkg::MSK_CMP) == a64dec_pkg::MAT_CMP_W) begin
      res_nxt.inst_class = a64dec_pkg::CLS_CMP_W;
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = {20'h00000, w[21:10]};
      res_nxt.reg_t      = a64dec_pkg::REG_ZR;
    end else if ((w & a64dec_pkg::MSK_LDST) == a64dec_pkg::MAT_UBFM_W) begin
      res_nxt.inst_class = a64dec_pkg::CLS_UBFM_W;
      res_nxt.reg_t      = w[4:0];
      res_nxt.reg_n      = w[9:5];
      res_nxt.uimm       = w;
    end else if ((w & a64dec_pkg::MSK_CB) == a64dec_pkg::MAT_CB) begin
      // Bit 24 selects CBNZ, bit 31 the 64-bit register form.
      case ({w[24], w[31]})
        2'b00:   res_nxt.inst_class = a64dec_pkg::CLS_CBZ_W;
        2'b01:   res_nxt.inst_class = a64dec_pkg::CLS_CBZ_X;
        2'b10:   res_nxt.inst_class = a64dec_pkg::CLS_CBNZ_W;
        default: res_nxt.inst_class = a64dec_pkg::CLS_CBNZ_X;
      endcase
      res_nxt.reg_t        = w[4:0];
      res_nxt.simm         = br_off;
      res_nxt.target_valid = 1'b1;
    end else if ((w & a64dec_pkg::MSK_BCOND) == a64dec_pkg::MAT_BCOND) begin
      res_nxt.inst_class   = a64dec_pkg::CLS_BCOND;
      res_nxt.cond_code    = w[3:0];
      res_nxt.simm         = br_off;
      res_nxt.target_valid = 1'b1;
    end else begin
      // Unknown word: report the generic register fields.
      res_nxt.reg_t = w[4:0];
      res_nxt.reg_n = w[9:5];
      res_nxt.reg_m = w[20:16];
    end

    // Branch target is the offset plus the sign-extended displacement.
    if (res_nxt.target_valid) begin
      res_nxt.branch_target = s0_offset_r + {{32{res_nxt.simm[31]}}, res_nxt.simm};
    end
  end

  // Result stage control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_ready) begin
      out_valid_r <= s0_valid_r;
    end
  end

  // Result stage payload.
  always_ff @(posedge clk) begin
    if (s1_load) begin
      res_r <= res_nxt;
    end
  end

  // Output ports.
  assign out_valid         = out_valid_r;
  assign out_inst_class    = res_r.inst_class;
  assign out_reg_t         = res_r.reg_t;
  assign out_reg_n         = res_r.reg_n;
  assign out_reg_m         = res_r.reg_m;
  assign out_uimm          = res_r.uimm;
  assign out_simm          = res_r.simm;
  assign out_shift_amount  = res_r.shift_amount;
  assign out_cond_code     = res_r.cond_code;
  assign out_target_valid  = res_r.target_valid;
  assign out_branch_target = res_r.branch_target;

  // A transfer at the input always lands in the input register.
  `A64D_ASSERT_NEXT(a_in_lands, in_xfer, s0_valid_r, "accepted word was not captured")

  // A held input item is kept while the result side stalls.
  `A64D_ASSERT_NEXT(a_s0_holds, s0_valid_r && !s1_ready, s0_valid_r && $stable(s0_word_r),
    "input register lost a stalled word")

  // Only branch classes carry a target.
  `A64D_ASSERT_SAME(a_tv_class, out_valid_r && res_r.target_valid,
    res_r.inst_class >= a64dec_pkg::CLS_CBZ_W, "target flagged on a non-branch class")

  // Without a target the target field reads zero.
  `A64D_ASSERT_SAME(a_tgt_zero, out_valid_r && !res_r.target_valid,
    res_r.branch_target == 64'd0, "branch target set without a valid target")

  // A condition code appears only on B.cond.
  `A64D_ASSERT_SAME(a_cc_bcond, out_valid_r && (res_r.cond_code != 4'd0),
    res_r.inst_class == a64dec_pkg::CLS_BCOND, "condition code set outside B.cond")

endmodule
